>>> hdl/rtrp_pkg.sv
package rtrp_pkg;

   localparam int unsigned NUM_PAIRS = 6;
   localparam logic [2:0] LAST_PAIR = 3'd5;
   localparam logic [16:0] Q_ONE = 17'd16384;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_ZERO = 2'd1;
   localparam logic [1:0] ST_TRI  = 2'd2;

   typedef struct packed {
      logic [1:0]  status;
      logic [2:0]  pair;
      logic        last;
      logic [15:0] d;
      logic [15:0] other;
      logic [34:0] n1;
      logic [34:0] n2;
      logic [31:0] pq;
      logic [50:0] dn1;
      logic [50:0] dn2;
   } job_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [2:0]         pair_index;
      logic signed [16:0] pos_x;
      logic signed [16:0] pos_y;
      logic signed [15:0] quat_z;
      logic signed [15:0] quat_w;
      logic               last;
   } rsp_type;

endpackage

>>> hdl/rtrp_fifo.sv
module rtrp_fifo #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ff];

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

>>> hdl/rtrp_sqrt.sv
// rounded root: largest n <= limit with n == 0 or (2n-1)^2 * den <= num
// one result bit at a time, in steps: candidate, square, two half products, compare
module rtrp_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] num,
   input  logic [31:0] den,
   input  logic [16:0] limit,
   output logic        done,
   output logic [16:0] root
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  bit_ff, bit_in;
   logic [1:0]  phase_ff, phase_in;
   logic [16:0] n_ff, n_in;
   logic [16:0] t_ff, t_in;
   logic [35:0] sq_ff, sq_in;
   logic [51:0] lo_ff, lo_in;
   logic [51:0] hi_ff, hi_in;
   logic [63:0] num_ff, num_in;
   logic [31:0] den_ff, den_in;
   logic [16:0] limit_ff, limit_in;
   logic [17:0] m;
   logic [67:0] prod;
   logic        fits;

   assign done = done_ff;
   assign root = n_ff;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      bit_in   = bit_ff;
      phase_in = phase_ff;
      n_in     = n_ff;
      t_in     = t_ff;
      sq_in    = sq_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      num_in   = num_ff;
      den_in   = den_ff;
      limit_in = limit_ff;
      m        = {t_ff, 1'b0} - 18'd1;
      prod     = {hi_ff, 16'b0} + {16'b0, lo_ff};
      fits     = (t_ff <= limit_ff) && (prod <= {4'b0, num_ff});
      if (start) begin
         busy_in  = 1'b1;
         bit_in   = 5'd16;
         phase_in = 2'd0;
         n_in     = '0;
         num_in   = num;
         den_in   = den;
         limit_in = limit;
      end else if (busy_ff) begin
         phase_in = phase_ff + 2'd1;
         case (phase_ff)
            2'd0: t_in = n_ff | (17'd1 << bit_ff);
            2'd1: sq_in = 36'(m) * 36'(m);
            2'd2: begin
               lo_in = 52'(sq_ff) * 52'(den_ff[15:0]);
               hi_in = 52'(sq_ff) * 52'(den_ff[31:16]);
            end
            default: begin
               if (fits) begin
                  n_in = t_ff;
               end
               if (bit_ff == 5'd0) begin
                  busy_in = 1'b0;
                  done_in = 1'b1;
               end else begin
                  bit_in = bit_ff - 5'd1;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      bit_ff   <= bit_in;
      phase_ff <= phase_in;
      n_ff     <= n_in;
      t_ff     <= t_in;
      sq_ff    <= sq_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      num_ff   <= num_in;
      den_ff   <= den_in;
      limit_ff <= limit_in;
   end

endmodule

>>> hdl/rtrp_front.sv
module rtrp_front import rtrp_pkg::*; #(
   parameter int unsigned RANGE_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [15:0] range_ab,
   input  logic [15:0] range_ac,
   input  logic [15:0] range_bc,
   output logic        job_push,
   output job_type     job_data,
   input  logic        job_full
);

   localparam int unsigned EW = (RANGE_WIDTH < 16) ? RANGE_WIDTH : 16;
   localparam logic [15:0] MASK = 16'((32'd1 << EW) - 32'd1);

   typedef enum logic [3:0] {
      F_IDLE  = 4'b0001,
      F_CLASS = 4'b0010,
      F_PREP  = 4'b0100,
      F_ISSUE = 4'b1000
   } fstate_type;

   fstate_type  state_ff, state_in;
   logic [15:0] ab_ff, ab_in, ac_ff, ac_in, bc_ff, bc_in;
   logic [2:0]  pair_ff, pair_in;
   logic [15:0] d_ff, d_in, other_ff, other_in;
   logic [34:0] n1_ff, n1_in, n2_ff, n2_in;
   logic [31:0] pq_ff, pq_in;
   logic [15:0] p, q, o;
   logic [16:0] a1, c2, e2;
   logic [17:0] b1;
   logic        zero_rng, bad_tri;

   assign full = (state_ff != F_IDLE);

   always_comb begin
      unique case (pair_ff[2:1])
         2'd0:    begin p = ab_ff; q = ac_ff; o = bc_ff; end
         2'd1:    begin p = ab_ff; q = bc_ff; o = ac_ff; end
         default: begin p = ac_ff; q = bc_ff; o = ab_ff; end
      endcase
      a1 = {1'b0, p} + {1'b0, q} - {1'b0, o};
      b1 = {2'b0, p} + {2'b0, q} + {2'b0, o};
      c2 = {1'b0, o} + {1'b0, q} - {1'b0, p};
      e2 = {1'b0, o} + {1'b0, p} - {1'b0, q};
      zero_rng = (ab_ff == '0) || (ac_ff == '0) || (bc_ff == '0);
      bad_tri  = ({1'b0, ab_ff} + {1'b0, ac_ff} <= {1'b0, bc_ff})
              || ({1'b0, ab_ff} + {1'b0, bc_ff} <= {1'b0, ac_ff})
              || ({1'b0, ac_ff} + {1'b0, bc_ff} <= {1'b0, ab_ff});
   end

   always_comb begin
      state_in = state_ff;
      ab_in    = ab_ff;
      ac_in    = ac_ff;
      bc_in    = bc_ff;
      pair_in  = pair_ff;
      d_in     = d_ff;
      other_in = other_ff;
      n1_in    = n1_ff;
      n2_in    = n2_ff;
      pq_in    = pq_ff;
      job_push = 1'b0;
      job_data = '0;
      unique case (state_ff)
         F_IDLE: begin
            if (push) begin
               ab_in    = range_ab & MASK;
               ac_in    = range_ac & MASK;
               bc_in    = range_bc & MASK;
               pair_in  = '0;
               state_in = F_CLASS;
            end
         end
         F_CLASS: begin
            if (zero_rng || bad_tri) begin
               job_data.status = zero_rng ? ST_ZERO : ST_TRI;
               job_data.last   = 1'b1;
               job_push        = !job_full;
               if (!job_full) begin
                  state_in = F_IDLE;
               end
            end else begin
               state_in = F_PREP;
            end
         end
         F_PREP: begin
            d_in     = pair_ff[0] ? q : p;
            other_in = pair_ff[0] ? p : q;
            n1_in    = 35'(a1) * 35'(b1);
            n2_in    = 35'(c2) * 35'(e2);
            pq_in    = 32'(p) * 32'(q);
            state_in = F_ISSUE;
         end
         default: begin
            job_data.status = ST_OK;
            job_data.pair   = pair_ff;
            job_data.last   = (pair_ff == LAST_PAIR);
            job_data.d      = d_ff;
            job_data.other  = other_ff;
            job_data.n1     = n1_ff;
            job_data.n2     = n2_ff;
            job_data.pq     = pq_ff;
            job_data.dn1    = 51'(d_ff) * 51'(n1_ff);
            job_data.dn2    = 51'(d_ff) * 51'(n2_ff);
            job_push        = !job_full;
            if (!job_full) begin
               pair_in  = pair_ff + 3'd1;
               state_in = (pair_ff == LAST_PAIR) ? F_IDLE : F_PREP;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      ab_ff    <= ab_in;
      ac_ff    <= ac_in;
      bc_ff    <= bc_in;
      pair_ff  <= pair_in;
      d_ff     <= d_in;
      other_ff <= other_in;
      n1_ff    <= n1_in;
      n2_ff    <= n2_in;
      pq_ff    <= pq_in;
   end

endmodule

>>> hdl/rtrp_back.sv
module rtrp_back import rtrp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    job_empty,
   input  job_type job_data,
   output logic    job_pop,
   output logic    rsp_push,
   output rsp_type rsp_data,
   input  logic    rsp_full
);

   typedef enum logic [2:0] {
      B_IDLE  = 3'b001,
      B_RUN   = 3'b010,
      B_WRITE = 3'b100
   } bstate_type;

   bstate_type  state_ff, state_in;
   job_type     job_ff, job_in;
   logic        start;
   logic [3:0]  done;
   logic [16:0] rx, ry, rz, rw;
   logic        neg_xw, neg_yz;

   assign start = (state_ff == B_IDLE) && !job_empty && (job_data.status == ST_OK);

   rtrp_sqrt u_sqrt_x (
      .clock, .reset, .start,
      .num   ({13'b0, job_data.dn1}),
      .den   ({16'b0, job_data.other}),
      .limit ({1'b0, job_data.d}),
      .done  (done[0]),
      .root  (rx)
   );

   rtrp_sqrt u_sqrt_y (
      .clock, .reset, .start,
      .num   ({13'b0, job_data.dn2}),
      .den   ({16'b0, job_data.other}),
      .limit ({1'b0, job_data.d}),
      .done  (done[1]),
      .root  (ry)
   );

   rtrp_sqrt u_sqrt_z (
      .clock, .reset, .start,
      .num   ({1'b0, job_data.n2, 28'b0}),
      .den   (job_data.pq),
      .limit (Q_ONE),
      .done  (done[2]),
      .root  (rz)
   );

   rtrp_sqrt u_sqrt_w (
      .clock, .reset, .start,
      .num   ({1'b0, job_data.n1, 28'b0}),
      .den   (job_data.pq),
      .limit (Q_ONE),
      .done  (done[3]),
      .root  (rw)
   );

   // pairs two and four point backward, every pair but the first is mirrored
   assign neg_xw = (job_ff.pair == 3'd2) || (job_ff.pair == 3'd4);
   assign neg_yz = (job_ff.pair != 3'd0);

   always_comb begin
      state_in = state_ff;
      job_in   = job_ff;
      job_pop  = 1'b0;
      rsp_push = 1'b0;
      rsp_data = '0;
      rsp_data.status     = job_ff.status;
      rsp_data.pair_index = job_ff.pair;
      rsp_data.last       = job_ff.last;
      if (job_ff.status == ST_OK) begin
         rsp_data.pos_x  = neg_xw ? -rx : rx;
         rsp_data.pos_y  = neg_yz ? -ry : ry;
         rsp_data.quat_z = neg_yz ? -rz[15:0] : rz[15:0];
         rsp_data.quat_w = neg_xw ? -rw[15:0] : rw[15:0];
      end
      unique case (state_ff)
         B_IDLE: begin
            if (!job_empty) begin
               job_pop  = 1'b1;
               job_in   = job_data;
               state_in = (job_data.status == ST_OK) ? B_RUN : B_WRITE;
            end
         end
         B_RUN: begin
            if (&done) begin
               state_in = B_WRITE;
            end
         end
         default: begin
            rsp_push = !rsp_full;
            if (!rsp_full) begin
               state_in = B_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
   end

endmodule

>>> hdl/triangle_range_to_relative_pose_core.sv
// triangle range to relative pose
// input queue side: drive req_range_ab/ac/bc with req_push; a beat is taken
// when req_push is high and req_full is low. a range of zero gives one result
// with status 1, a failed triangle inequality one with status 2, both with
// last set. a good triangle gives six results, pair_index 0 to 5, last on 5.
// result queue side: the oldest result sits on the rsp_ ports while
// rsp_empty is low and leaves on a clock with rsp_pop high.
// an accepted beat is registered and then classified; each good result is
// computed by four rounding square-root units that resolve one bit at a
// time over 17 bits and finish a result before they take the next job.
// a job queue of four entries sits between classification and the root units
// and a two-entry result queue follows them; a stalled receiver stops the
// root units once the result queue fills and the front once the job queue
// fills too; nothing is dropped.
// reset (synchronous, active high) empties both queues and idles the block;
// no pass over storage is needed afterward.
module triangle_range_to_relative_pose_core import rtrp_pkg::*; #(
   parameter int unsigned RANGE_WIDTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic [15:0]        req_range_ab,
   input  logic [15:0]        req_range_ac,
   input  logic [15:0]        req_range_bc,
   input  logic               rsp_pop,
   output logic               rsp_empty,
   output logic [1:0]         rsp_status,
   output logic [2:0]         rsp_pair_index,
   output logic signed [16:0] rsp_pos_x,
   output logic signed [16:0] rsp_pos_y,
   output logic signed [15:0] rsp_quat_z,
   output logic signed [15:0] rsp_quat_w,
   output logic               rsp_last
);

   job_type job_in_data, job_out_data;
   rsp_type res_in_data, res_out_data;
   logic    job_push, job_full, job_pop, job_empty;
   logic    res_push, res_full;

   rtrp_front #(.RANGE_WIDTH(RANGE_WIDTH)) u_front (
      .clock, .reset,
      .push     (req_push),
      .full     (req_full),
      .range_ab (req_range_ab),
      .range_ac (req_range_ac),
      .range_bc (req_range_bc),
      .job_push,
      .job_data (job_in_data),
      .job_full
   );

   rtrp_fifo #(.WIDTH($bits(job_type)), .DEPTH(4)) u_job_q (
      .clock, .reset,
      .push      (job_push),
      .push_data (job_in_data),
      .full      (job_full),
      .pop       (job_pop),
      .pop_data  (job_out_data),
      .empty     (job_empty)
   );

   rtrp_back u_back (
      .clock, .reset,
      .job_empty,
      .job_data (job_out_data),
      .job_pop,
      .rsp_push (res_push),
      .rsp_data (res_in_data),
      .rsp_full (res_full)
   );

   rtrp_fifo #(.WIDTH($bits(rsp_type)), .DEPTH(2)) u_rsp_q (
      .clock, .reset,
      .push      (res_push),
      .push_data (res_in_data),
      .full      (res_full),
      .pop       (rsp_pop),
      .pop_data  (res_out_data),
      .empty     (rsp_empty)
   );

   assign rsp_status     = res_out_data.status;
   assign rsp_pair_index = res_out_data.pair_index;
   assign rsp_pos_x      = res_out_data.pos_x;
   assign rsp_pos_y      = res_out_data.pos_y;
   assign rsp_quat_z     = res_out_data.quat_z;
   assign rsp_quat_w     = res_out_data.quat_w;
   assign rsp_last       = res_out_data.last;

endmodule

>>> tb/tb_triangle_range_to_relative_pose_core.sv
module tb_triangle_range_to_relative_pose_core;
   import rtrp_pkg::*;

   localparam int RANDOM_ITEMS = 460;
   localparam int STALL_LIMIT  = 5000;
   localparam int DRAIN_CYCLES = 600;
   localparam int HOLD_CYCLES  = 400;

   typedef struct {
      logic [15:0] ab;
      logic [15:0] ac;
      logic [15:0] bc;
      bit          typed_exp;
      logic [1:0]  status;
   } range_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_push = 1'b0;
   logic               req_full;
   logic [15:0]        req_range_ab = '0;
   logic [15:0]        req_range_ac = '0;
   logic [15:0]        req_range_bc = '0;
   logic               rsp_pop = 1'b0;
   logic               rsp_empty;
   logic [1:0]         rsp_status;
   logic [2:0]         rsp_pair_index;
   logic signed [16:0] rsp_pos_x;
   logic signed [16:0] rsp_pos_y;
   logic signed [15:0] rsp_quat_z;
   logic signed [15:0] rsp_quat_w;
   logic               rsp_last;

   rsp_type pose_q[$];
   int      err_count = 0;
   int      idle_count = 0;
   bit      hold_rsp = 1'b0;

   triangle_range_to_relative_pose_core DUT (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full),
      .req_range_ab(req_range_ab), .req_range_ac(req_range_ac),
      .req_range_bc(req_range_bc),
      .rsp_pop(rsp_pop), .rsp_empty(rsp_empty),
      .rsp_status(rsp_status), .rsp_pair_index(rsp_pair_index),
      .rsp_pos_x(rsp_pos_x), .rsp_pos_y(rsp_pos_y),
      .rsp_quat_z(rsp_quat_z), .rsp_quat_w(rsp_quat_w),
      .rsp_last(rsp_last)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // largest n in [0,hi] with n == 0 or (2n-1)^2 * den <= num
   function automatic longint unsigned round_root(longint unsigned num,
         longint unsigned den, longint unsigned hi);
      longint unsigned lo, mid, m;
      lo = 0;
      while (lo < hi) begin
         mid = lo + (hi - lo + 1) / 2;
         m = 2 * mid - 1;
         if (m * m * den <= num) lo = mid;
         else hi = mid - 1;
      end
      return lo;
   endfunction

   function automatic rsp_type error_pose(logic [1:0] st);
      rsp_type r;
      r = '0;
      r.status = st;
      r.last = 1'b1;
      return r;
   endfunction

   function automatic void predict_pose(logic [15:0] ab, logic [15:0] ac, logic [15:0] bc);
      longint unsigned a, b, c, p, q, o, n1, n2, qz, qw, d, oth, px, py;
      int pair;
      rsp_type r;
      a = ab; b = ac; c = bc;
      if (a == 0 || b == 0 || c == 0) begin
         pose_q.push_back(error_pose(ST_ZERO));
         return;
      end
      if (a + b <= c || a + c <= b || b + c <= a) begin
         pose_q.push_back(error_pose(ST_TRI));
         return;
      end
      for (int node = 0; node < 3; node++) begin
         // apex sides p,q and opposite side o per node
         p = (node == 2) ? b : a;
         q = (node == 0) ? b : c;
         o = (node == 0) ? c : (node == 1) ? b : a;
         n1 = (p + q - o) * (p + q + o);
         n2 = (o + q - p) * (o + p - q);
         qz = round_root(n2 << 28, p * q, Q_ONE);
         qw = round_root(n1 << 28, p * q, Q_ONE);
         for (int half = 0; half < 2; half++) begin
            pair = node * 2 + half;
            d = half ? q : p;
            oth = half ? p : q;
            px = round_root(d * n1, oth, d);
            py = round_root(d * n2, oth, d);
            r.status = ST_OK;
            r.pair_index = pair[2:0];
            r.pos_x = (pair == 2 || pair == 4) ? -$signed({1'b0, px[15:0]})
                                               : $signed({1'b0, px[15:0]});
            r.pos_y = (pair != 0) ? -$signed({1'b0, py[15:0]}) : $signed({1'b0, py[15:0]});
            r.quat_z = (pair != 0) ? -$signed(qz[15:0]) : $signed(qz[15:0]);
            r.quat_w = (pair == 2 || pair == 4) ? -$signed(qw[15:0]) : $signed(qw[15:0]);
            r.last = (pair[2:0] == LAST_PAIR);
            pose_q.push_back(r);
         end
      end
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      err_count++;
   endtask

   // result side monitor and checker
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pose_q.size() == 0) begin
            report_mismatch("unexpected beat, pair", rsp_pair_index, -1);
         end else begin
            want = pose_q.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", rsp_status, want.status);
            if (rsp_pair_index !== want.pair_index)
               report_mismatch("pair_index", rsp_pair_index, want.pair_index);
            if (rsp_pos_x !== want.pos_x) report_mismatch("pos_x", rsp_pos_x, want.pos_x);
            if (rsp_pos_y !== want.pos_y) report_mismatch("pos_y", rsp_pos_y, want.pos_y);
            if (rsp_quat_z !== want.quat_z)
               report_mismatch("quat_z", rsp_quat_z, want.quat_z);
            if (rsp_quat_w !== want.quat_w)
               report_mismatch("quat_w", rsp_quat_w, want.quat_w);
            if (rsp_last !== want.last) report_mismatch("last", rsp_last, want.last);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         idle_count <= 0;
      end else if (idle_count >= STALL_LIMIT) begin
         $display("tb_triangle_range_to_relative_pose_core NOT OK");
         $finish;
      end else begin
         idle_count <= idle_count + 1;
      end
   end

   // receiver
   initial begin
      int gap;
      @(negedge reset);
      forever begin
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_pop <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         gap = $urandom_range(0, 7);
         if (gap > 0) begin
            rsp_pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
      end
   end

   task automatic send_ranges(logic [15:0] ab, logic [15:0] ac, logic [15:0] bc);
      int gap;
      gap = $urandom_range(0, 7);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_range_ab <= ab;
      req_range_ac <= ac;
      req_range_bc <= bc;
      do @(posedge clock); while (req_full);
   endtask

   initial begin
      range_row_type rows[16];
      logic [15:0] ab, ac, bc;
      int unsigned lo, hi;
      rows = '{
         '{16'd0, 16'd5, 16'd5, 1'b1, ST_ZERO},
         '{16'd5, 16'd0, 16'd5, 1'b1, ST_ZERO},
         '{16'd5, 16'd5, 16'd0, 1'b1, ST_ZERO},
         '{16'd0, 16'd0, 16'd0, 1'b1, ST_ZERO},
         '{16'd1, 16'd1, 16'd2, 1'b1, ST_TRI},
         '{16'd1, 16'd1, 16'd65535, 1'b1, ST_TRI},
         '{16'd65535, 16'd1, 16'd1, 1'b1, ST_TRI},
         '{16'd2, 16'd65535, 16'd1, 1'b1, ST_TRI},
         '{16'd1, 16'd1, 16'd1, 1'b0, ST_OK},
         '{16'd65535, 16'd65535, 16'd65535, 1'b0, ST_OK},
         '{16'd65535, 16'd65535, 16'd1, 1'b0, ST_OK},
         '{16'd3, 16'd4, 16'd5, 1'b0, ST_OK},
         '{16'd32768, 16'd32768, 16'd65535, 1'b0, ST_OK},
         '{16'hAAAA, 16'h5555, 16'hAAAA, 1'b0, ST_OK},
         '{16'h5555, 16'hAAAA, 16'hAAAA, 1'b0, ST_OK},
         '{16'd1000, 16'd1, 16'd1000, 1'b0, ST_OK}
      };
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      foreach (rows[i]) begin
         if (rows[i].typed_exp) pose_q.push_back(error_pose(rows[i].status));
         else predict_pose(rows[i].ab, rows[i].ac, rows[i].bc);
         send_ranges(rows[i].ab, rows[i].ac, rows[i].bc);
      end
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 100) hold_rsp = 1'b1;
         if (n == 300) begin
            req_push <= 1'b0;
            wait (pose_q.size() == 0);
            @(posedge clock);
         end
         ab = 16'($urandom);
         ac = 16'($urandom);
         bc = 16'($urandom);
         case ($urandom_range(0, 9))
            0: ;  // raw noise, mostly failed triangles
            1: bc = 16'd0;
            2: bc = ab + ac;  // degenerate, may wrap
            default: begin
               if (ab == 16'd0) ab = 16'd1;
               if (ac == 16'd0) ac = 16'd1;
               lo = (ab > ac) ? 32'(ab - ac) + 32'd1 : 32'(ac - ab) + 32'd1;
               hi = 32'(ab) + 32'(ac) - 32'd1;
               if (hi > 65535) hi = 65535;
               bc = 16'($urandom_range(lo, hi));
            end
         endcase
         predict_pose(ab, ac, bc);
         send_ranges(ab, ac, bc);
      end
      req_push <= 1'b0;
      wait (pose_q.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (err_count == 0) $display("tb_triangle_range_to_relative_pose_core OK");
      else $display("tb_triangle_range_to_relative_pose_core NOT OK");
      $finish;
   end

endmodule
